@@ sv/lcs_pkg.sv @@
// Shared constants and types for the longest common subsequence core.
package lcs_pkg;

	localparam int MAX_LEN   = 32;
	localparam int DIM       = MAX_LEN + 1;
	localparam int LEN_W     = $clog2(MAX_LEN + 1);
	localparam int IDX_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int TBL_DEPTH = DIM * DIM;
	localparam int TBL_AW    = $clog2(TBL_DEPTH);
	localparam int SYM_W     = 8;
	localparam int OP_W      = 2;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND_FIRST  = 2'd0,
		OP_APPEND_SECOND = 2'd1,
		OP_COMPUTE       = 2'd2
	} op_t;

	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [TBL_AW-1:0] tbl_addr_t;
	typedef logic [SYM_W-1:0]  sym_t;

endpackage

@@ sv/lcs_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module lcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/longest_common_subsequence_core.sv @@
// Top level of the longest common subsequence core: string load, table fill, backtrack, emit.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | s_tdata[7:0] symbol, s_tuser[1:0] operation
//  m_*      | out | m_tvalid/m_tready  | m_tdata[7:0] out_symbol, m_tuser found, m_tlast
//
// Append items are taken back to back while idle. A compute item fills the length table
// through its single read port at one cell per cycle, then backtracks: a matching step takes
// the check state alone, any other step the check, up and left states (two table reads in
// turn through the same port), and a last check closes; then it emits one item per cycle as
// m_tready allows. Reset clears the lengths, the sequencer and the output register; string
// and table contents need no clearing. A stalled output holds its item; appends wait for idle.
module longest_common_subsequence_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] symbol
	input  logic [1:0] s_tuser,   // [1:0] operation
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_symbol
	output logic       m_tuser,   // [0] found
	output logic       m_tlast
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_BT_CHECK,
		ST_BT_UP,
		ST_BT_LEFT,
		ST_EMIT
	} state_t;

	localparam lcs_pkg::tbl_addr_t DIM_A   = lcs_pkg::TBL_AW'(lcs_pkg::DIM);
	localparam lcs_pkg::len_t      MAX_L   = lcs_pkg::LEN_W'(lcs_pkg::MAX_LEN);
	localparam lcs_pkg::len_t      ONE_L   = lcs_pkg::LEN_W'(1);

	state_t state;

	// String stores and the reverse buffer: one variable read each
	lcs_pkg::sym_t first_q  [lcs_pkg::MAX_LEN];
	lcs_pkg::sym_t second_q [lcs_pkg::MAX_LEN];
	lcs_pkg::sym_t rev_q    [lcs_pkg::MAX_LEN];

	lcs_pkg::len_t len_a_q, len_b_q;

	// Fill issue side
	lcs_pkg::len_t     fi_q, fj_q;
	logic              f_issue_q;
	lcs_pkg::tbl_addr_t f_base_q;

	// Fill compute stage
	logic               cell_valid_s1, cell_last_s1, first_col_s1, top_row_s1, match_s1;
	lcs_pkg::tbl_addr_t waddr_s1, uaddr_s1;
	lcs_pkg::len_t      left_q, diag_q;
	logic               fwd_valid_q;
	lcs_pkg::tbl_addr_t fwd_addr_q;
	lcs_pkg::len_t      fwd_data_q;

	// Backtrack
	lcs_pkg::len_t      bi_q, bj_q, up_q, cnt_q;
	lcs_pkg::tbl_addr_t b_base_q;

	// Emit
	lcs_pkg::len_t e_q;
	logic          m_valid_q, m_found_q, m_last_q;
	lcs_pkg::sym_t m_sym_q;

	// Table memory
	logic               tbl_we;
	lcs_pkg::tbl_addr_t tbl_waddr, tbl_raddr;
	lcs_pkg::len_t      tbl_wdata, tbl_rdata;

	lcs_ram #(
		.WIDTH(lcs_pkg::LEN_W),
		.DEPTH(lcs_pkg::TBL_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(tbl_waddr),
		.wdata(tbl_wdata),
		.raddr(tbl_raddr),
		.rdata(tbl_rdata)
	);

	// Symbol reads: the fill walk and the backtrack share one index per string
	lcs_pkg::len_t a_pos, b_pos;
	logic [lcs_pkg::IDX_W-1:0] a_idx, b_idx;
	lcs_pkg::sym_t a_sym, b_sym;
	logic sym_eq;

	always_comb begin
		a_pos  = (state == ST_FILL) ? fi_q - ONE_L : bi_q - ONE_L;
		b_pos  = (state == ST_FILL) ? fj_q - ONE_L : bj_q - ONE_L;
		a_idx  = a_pos[lcs_pkg::IDX_W-1:0];
		b_idx  = b_pos[lcs_pkg::IDX_W-1:0];
		a_sym  = first_q[a_idx];
		b_sym  = second_q[b_idx];
		sym_eq = (a_sym == b_sym);
	end

	// Table read address: up neighbour while filling and on a backtrack check,
	// left neighbour on the second backtrack read
	always_comb begin
		case (state)
			ST_FILL:  tbl_raddr = f_base_q - DIM_A + lcs_pkg::TBL_AW'(fj_q);
			ST_BT_UP: tbl_raddr = b_base_q + lcs_pkg::TBL_AW'(bj_q) - lcs_pkg::TBL_AW'(1);
			default:  tbl_raddr = b_base_q - DIM_A + lcs_pkg::TBL_AW'(bj_q);
		endcase
	end

	// Cell update; forward the cell written last cycle when it is the one above
	lcs_pkg::len_t up_raw, up_v, left_v, diag_v, cell_v;

	always_comb begin
		up_raw = (fwd_valid_q && (fwd_addr_q == uaddr_s1)) ? fwd_data_q : tbl_rdata;
		up_v   = top_row_s1   ? '0 : up_raw;
		left_v = first_col_s1 ? '0 : left_q;
		diag_v = first_col_s1 ? '0 : diag_q;
		if (match_s1) begin
			cell_v = diag_v + ONE_L;
		end else if (up_v >= left_v) begin
			cell_v = up_v;
		end else begin
			cell_v = left_v;
		end
	end

	assign tbl_we    = cell_valid_s1;
	assign tbl_waddr = waddr_s1;
	assign tbl_wdata = cell_v;

	// Backtrack decision values
	lcs_pkg::len_t bt_left;
	logic          bt_done, bt_push, load_ok;

	always_comb begin
		bt_left = (bj_q == ONE_L) ? '0 : tbl_rdata;
		bt_done = (bi_q == '0) || (bj_q == '0);
		bt_push = (state == ST_BT_CHECK) && !bt_done && sym_eq;
		load_ok = !m_valid_q || m_tready;
	end

	assign s_tready = (state == ST_IDLE);

	logic         s_fire;
	lcs_pkg::op_t s_op;
	assign s_fire = s_tvalid && s_tready;
	assign s_op   = lcs_pkg::op_t'(s_tuser);

	// Payload stores: append into the strings, push matches into the reverse buffer
	always_ff @(posedge clk) begin
		if (s_fire && (s_op == lcs_pkg::OP_APPEND_FIRST) && (len_a_q < MAX_L)) begin
			first_q[len_a_q[lcs_pkg::IDX_W-1:0]] <= s_tdata;
		end
		if (s_fire && (s_op == lcs_pkg::OP_APPEND_SECOND) && (len_b_q < MAX_L)) begin
			second_q[len_b_q[lcs_pkg::IDX_W-1:0]] <= s_tdata;
		end
		if (bt_push) begin
			rev_q[cnt_q[lcs_pkg::IDX_W-1:0]] <= a_sym;
		end
	end

	// Fill pipeline stage registers
	always_ff @(posedge clk) begin
		first_col_s1 <= (fj_q == ONE_L);
		top_row_s1   <= (fi_q == ONE_L);
		match_s1     <= sym_eq;
		waddr_s1     <= f_base_q + lcs_pkg::TBL_AW'(fj_q);
		uaddr_s1     <= tbl_raddr;
		fwd_addr_q   <= waddr_s1;
		fwd_data_q   <= cell_v;
		if (cell_valid_s1) begin
			left_q <= cell_v;
			diag_q <= up_v;
		end
	end

	// Sequencer: state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state         <= ST_IDLE;
			len_a_q       <= '0;
			len_b_q       <= '0;
			fi_q          <= '0;
			fj_q          <= '0;
			f_issue_q     <= 1'b0;
			f_base_q      <= '0;
			cell_valid_s1 <= 1'b0;
			cell_last_s1  <= 1'b0;
			fwd_valid_q   <= 1'b0;
			bi_q          <= '0;
			bj_q          <= '0;
			up_q          <= '0;
			cnt_q         <= '0;
			b_base_q      <= '0;
			e_q           <= '0;
			m_valid_q     <= 1'b0;
			m_found_q     <= 1'b0;
			m_last_q      <= 1'b0;
			m_sym_q       <= '0;
		end else begin
			fwd_valid_q   <= cell_valid_s1;
			cell_valid_s1 <= (state == ST_FILL) && f_issue_q;
			cell_last_s1  <= (fi_q == len_a_q) && (fj_q == len_b_q);

			// drop a taken item; the emit state reloads the register itself
			if (m_valid_q && m_tready && (state != ST_EMIT)) begin
				m_valid_q <= 1'b0;
			end

			case (state)
				ST_IDLE: begin
					if (s_fire) begin
						case (s_op)
							lcs_pkg::OP_APPEND_FIRST: begin
								if (len_a_q < MAX_L) begin
									len_a_q <= len_a_q + ONE_L;
								end
							end
							lcs_pkg::OP_APPEND_SECOND: begin
								if (len_b_q < MAX_L) begin
									len_b_q <= len_b_q + ONE_L;
								end
							end
							lcs_pkg::OP_COMPUTE: begin
								cnt_q <= '0;
								bi_q  <= len_a_q;
								bj_q  <= len_b_q;
								if ((len_a_q == '0) || (len_b_q == '0)) begin
									// nothing to fill: backtrack ends at once
									state <= ST_BT_CHECK;
								end else begin
									fi_q      <= ONE_L;
									fj_q      <= ONE_L;
									f_base_q  <= DIM_A;
									f_issue_q <= 1'b1;
									state     <= ST_FILL;
								end
							end
							default: begin
							end
						endcase
					end
				end

				ST_FILL: begin
					// advance the issue walk row by row
					if (f_issue_q) begin
						if (fj_q == len_b_q) begin
							fj_q     <= ONE_L;
							fi_q     <= fi_q + ONE_L;
							f_base_q <= f_base_q + DIM_A;
							if (fi_q == len_a_q) begin
								f_issue_q <= 1'b0;
							end
						end else begin
							fj_q <= fj_q + ONE_L;
						end
					end
					// last cell written: start the walk back from the corner
					if (cell_valid_s1 && cell_last_s1) begin
						b_base_q <= waddr_s1 - lcs_pkg::TBL_AW'(len_b_q);
						state    <= ST_BT_CHECK;
					end
				end

				ST_BT_CHECK: begin
					if (bt_done) begin
						e_q     <= cnt_q;
						len_a_q <= '0;
						len_b_q <= '0;
						state   <= ST_EMIT;
					end else if (sym_eq) begin
						cnt_q    <= cnt_q + ONE_L;
						bi_q     <= bi_q - ONE_L;
						bj_q     <= bj_q - ONE_L;
						b_base_q <= b_base_q - DIM_A;
					end else begin
						state <= ST_BT_UP;
					end
				end

				ST_BT_UP: begin
					up_q  <= (bi_q == ONE_L) ? '0 : tbl_rdata;
					state <= ST_BT_LEFT;
				end

				ST_BT_LEFT: begin
					if (up_q >= bt_left) begin
						bi_q     <= bi_q - ONE_L;
						b_base_q <= b_base_q - DIM_A;
					end else begin
						bj_q <= bj_q - ONE_L;
					end
					state <= ST_BT_CHECK;
				end

				ST_EMIT: begin
					if (load_ok) begin
						m_valid_q <= 1'b1;
						if (e_q == '0) begin
							// empty subsequence: one marker item
							m_sym_q   <= '0;
							m_found_q <= 1'b0;
							m_last_q  <= 1'b1;
							state     <= ST_IDLE;
						end else begin
							m_sym_q   <= rev_q[e_q[lcs_pkg::IDX_W-1:0] -
								lcs_pkg::IDX_W'(1)];
							m_found_q <= 1'b1;
							m_last_q  <= (e_q == ONE_L);
							e_q       <= e_q - ONE_L;
							if (e_q == ONE_L) begin
								state <= ST_IDLE;
							end
						end
					end
				end

				default: begin
					state <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_sym_q;
	assign m_tuser  = m_found_q;
	assign m_tlast  = m_last_q;

	// A table cell never exceeds the maximum string length
	a_cell_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_we |-> (tbl_wdata <= MAX_L))
		else $error("table cell above string limit");

	// The reverse buffer never overflows during a walk back
	a_rev_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bt_push |-> (cnt_q < MAX_L))
		else $error("reverse buffer overflow");

	// An empty result is always the closing item of its run
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> m_tlast)
		else $error("empty result not marked last");

endmodule
